// ===== sv/erht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execute-redirect hook table package
// Field widths, operation and status codes, and region map geometry shared
// by the table sequencer and the region map.
// ----------------------------------------------------------------------------
package erht_pkg;

	// Beat field widths.
	localparam int OP_W     = 2;
	localparam int PFN_W    = 52;
	localparam int EXEC_W   = 32;
	localparam int STATUS_W = 3;

	// Stored part of the original frame.
	localparam int FRAME_W = 27;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOSPARE  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

	// Region map: 512 regions per directory, held as rows of 64 flags.
	localparam int RGN_ROW_BITS    = 64;
	localparam int RGN_SEL_W       = 6;
	localparam int RGN_ROWS_PER_PD = 8;

	// Commands from the sequencer to the region map.
	typedef struct packed {
		logic look;
		logic set;
	} rgn_cmd_t;

endpackage

// ===== sv/erht_region_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region split map
// One flag per 2 MB region, set once the region has been split. Rows of 64
// flags live in a synchronous memory; a clearing pass after reset zeroes it.
// ----------------------------------------------------------------------------
module erht_region_map
	import erht_pkg::*;
#(
	parameter int PD_COUNT = 64,
	localparam int ROWS = PD_COUNT * RGN_ROWS_PER_PD,
	localparam int RW = $clog2(ROWS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgn_cmd_t             cmd,
	input  logic [RW-1:0]        row,
	input  logic [RGN_SEL_W-1:0] bit_sel,
	output logic                 ready,
	output logic                 is_large
);

	logic [RGN_ROW_BITS-1:0] rgn_mem [ROWS];
	logic [RGN_ROW_BITS-1:0] rdata_q;
	logic [RW-1:0]           row_q;
	logic [RGN_SEL_W-1:0]    bit_q;
	logic                    clearing_q;
	logic [RW-1:0]           clr_row_q;
	logic                    mem_we;
	logic [RW-1:0]           mem_waddr;
	logic [RGN_ROW_BITS-1:0] mem_wdata;

	// Write port: clearing pass, or set of the flag in the row just read.
	always_comb begin
		mem_we    = clearing_q || cmd.set;
		mem_waddr = clearing_q ? clr_row_q : row_q;
		mem_wdata = clearing_q ? '0 : (rdata_q | (RGN_ROW_BITS'(1) << bit_q));
	end

	// Memory array with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rgn_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.look) begin
			rdata_q <= rgn_mem[row];
		end
	end

	// Hold the address of the last lookup for the following set.
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			row_q <= row;
			bit_q <= bit_sel;
		end
	end

	// Clearing pass after reset, one row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ready    = !clearing_q;
	assign is_large = !rdata_q[bit_q];

endmodule

// ===== sv/exec_redirect_hook_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execute-redirect hook table
// Pool of hook slots mapping an original page frame to an execute frame,
// with a per-region split map and a count of spare page tables used.
// ----------------------------------------------------------------------------
// Each request beat returns exactly one response beat. The hook slots live in
// one single-port-read synchronous memory that is walked one slot per cycle,
// so every operation that reaches the slots costs a full pass over them.
// A find, an insert and a remove that finds no match make one pass; a remove
// that hits makes a search pass, then an age-update pass. A pool-full or
// range failure, an unknown operation and a spare-table failure respond
// without a pass over the slots. The next request is taken at the earliest
// in the cycle after the response is loaded. After reset the block runs a
// clearing pass and takes no request until both the slot memory and the
// region map are zeroed, the region map one 64-region row per cycle. A
// finished response waits in the output register while the next request
// is already taken.
// ----------------------------------------------------------------------------
module exec_redirect_hook_table_top
	import erht_pkg::*;
#(
	parameter int HOOK_SLOTS   = 64,
	parameter int PD_COUNT     = 64,
	parameter int SPARE_TABLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // operation[1:0], orig_frame[53:2], exec_frame[85:54], zeros
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status[2:0], found_exec[34:3], zeros
);

	localparam int SAW  = (HOOK_SLOTS > 1) ? $clog2(HOOK_SLOTS) : 1;
	localparam int AGW  = SAW;
	localparam int VCW  = $clog2(HOOK_SLOTS + 1);
	localparam int SPW  = (SPARE_TABLES > 0) ? $clog2(SPARE_TABLES + 1) : 1;
	localparam int ROWS = PD_COUNT * RGN_ROWS_PER_PD;
	localparam int RW   = $clog2(ROWS);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_REGION   = 3'd3;
	localparam logic [2:0] S_SCAN     = 3'd4;
	localparam logic [2:0] S_SCAN_END = 3'd5;
	localparam logic [2:0] S_FINISH   = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	// Pass kinds over the slot memory.
	localparam logic [1:0] M_INSERT = 2'd0;
	localparam logic [1:0] M_MATCH  = 2'd1;
	localparam logic [1:0] M_REMOVE = 2'd2;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] orig;
		logic [EXEC_W-1:0]  exec;
		logic [AGW-1:0]     age;
	} slot_t;

	slot_t slot_mem [HOOK_SLOTS];

	logic [2:0]          state_q;
	logic [1:0]          mode_q;
	logic [SAW-1:0]      idx_q;
	logic                clr_done_q;
	logic                pend_s1;
	logic [SAW-1:0]      addr_s1;
	slot_t               rd_data_s1;
	logic [OP_W-1:0]     op_q;
	logic [PFN_W-1:0]    pfn_q;
	logic [EXEC_W-1:0]   exec_q;
	logic [VCW-1:0]      valid_cnt_q;
	logic [SPW-1:0]      spare_used_q;
	logic                placed_q;
	logic                best_found_q;
	logic [AGW-1:0]      best_age_q;
	logic [SAW-1:0]      best_idx_q;
	logic [EXEC_W-1:0]   best_exec_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [EXEC_W-1:0]   res_found_q;
	logic                m_valid_q;
	logic [39:0]         m_data_q;

	logic                slot_rd_en;
	logic                slot_we;
	logic [SAW-1:0]      slot_waddr;
	slot_t               slot_wdata;
	logic                scan_last;
	logic                hit_s1;
	logic                pool_full;
	logic                out_of_range;
	rgn_cmd_t            rgn_cmd;
	logic [RW-1:0]       rgn_row;
	logic                rgn_ready;
	logic                rgn_large;
	logic                spare_exhausted;

	// Region split map.
	erht_region_map #(
		.PD_COUNT (PD_COUNT)
	) u_region_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rgn_cmd),
		.row      (rgn_row),
		.bit_sel  (pfn_q[14:9]),
		.ready    (rgn_ready),
		.is_large (rgn_large)
	);

	// Request decode: checks and region address.
	always_comb begin
		pool_full       = (valid_cnt_q == VCW'(HOOK_SLOTS));
		out_of_range    = (pfn_q[35:27] != 9'd0) || ({1'b0, pfn_q[26:18]} >= 10'(PD_COUNT));
		rgn_row         = RW'({pfn_q[26:18], pfn_q[17:15]});
		spare_exhausted = (spare_used_q >= SPW'(SPARE_TABLES));
		scan_last       = (idx_q == SAW'(HOOK_SLOTS - 1));
		rgn_cmd.look    = (state_q == S_DISPATCH) && (op_q == OP_INSERT) &&
			!pool_full && !out_of_range;
		rgn_cmd.set     = (state_q == S_REGION) && rgn_large && !spare_exhausted;
	end

	// Slot compare for the entry read in the previous cycle.
	assign hit_s1 = rd_data_s1.valid && (pfn_q[51:27] == 25'd0) &&
		(rd_data_s1.orig == pfn_q[FRAME_W-1:0]);

	// Slot write-back: clearing pass, or the modified entry of the current pass.
	always_comb begin
		slot_rd_en = (state_q == S_SCAN);
		slot_we    = 1'b0;
		slot_waddr = addr_s1;
		slot_wdata = rd_data_s1;
		if (state_q == S_CLEAR) begin
			slot_we    = !clr_done_q;
			slot_waddr = idx_q;
			slot_wdata = '0;
		end else if (pend_s1) begin
			unique case (mode_q)
				M_INSERT: begin
					if (rd_data_s1.valid) begin
						slot_we        = 1'b1;
						slot_wdata.age = rd_data_s1.age + AGW'(1);
					end else if (!placed_q) begin
						slot_we          = 1'b1;
						slot_wdata.valid = 1'b1;
						slot_wdata.orig  = pfn_q[FRAME_W-1:0];
						slot_wdata.exec  = exec_q;
						slot_wdata.age   = '0;
					end
				end
				M_REMOVE: begin
					if (addr_s1 == best_idx_q) begin
						slot_we          = 1'b1;
						slot_wdata.valid = 1'b0;
					end else if (rd_data_s1.valid && (rd_data_s1.age > best_age_q)) begin
						slot_we        = 1'b1;
						slot_wdata.age = rd_data_s1.age - AGW'(1);
					end
				end
				default: begin
					slot_we = 1'b0;
				end
			endcase
		end
	end

	// Slot memory with a registered read.
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_rd_en) begin
			rd_data_s1 <= slot_mem[idx_q];
		end
		addr_s1 <= idx_q;
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tdata[1:0];
			pfn_q  <= s_tdata[53:2];
			exec_q <= s_tdata[85:54];
		end
	end

	// Sequencer, pass bookkeeping and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= M_MATCH;
			idx_q        <= '0;
			clr_done_q   <= 1'b0;
			pend_s1      <= 1'b0;
			valid_cnt_q  <= '0;
			spare_used_q <= '0;
			placed_q     <= 1'b0;
			best_found_q <= 1'b0;
			best_age_q   <= '0;
			best_idx_q   <= '0;
			best_exec_q  <= '0;
			res_status_q <= STAT_OK;
			res_found_q  <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			pend_s1 <= (state_q == S_SCAN);

			// A taken beat empties the output register unless a new one loads now.
			if (m_valid_q && m_tready && (state_q != S_RESP)) begin
				m_valid_q <= 1'b0;
			end

			// Per-entry bookkeeping of the running pass.
			if (pend_s1) begin
				if ((mode_q == M_INSERT) && !rd_data_s1.valid) begin
					placed_q <= 1'b1;
				end
				if ((mode_q == M_MATCH) && hit_s1 &&
						(!best_found_q || (rd_data_s1.age < best_age_q))) begin
					best_found_q <= 1'b1;
					best_age_q   <= rd_data_s1.age;
					best_idx_q   <= addr_s1;
					best_exec_q  <= rd_data_s1.exec;
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					if (!clr_done_q) begin
						if (scan_last) begin
							clr_done_q <= 1'b1;
							idx_q      <= '0;
						end else begin
							idx_q <= idx_q + SAW'(1);
						end
					end else if (rgn_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_found_q <= '0;
					priority case (op_q)
						OP_INSERT: begin
							if (pool_full) begin
								res_status_q <= STAT_FULL;
								state_q      <= S_RESP;
							end else if (out_of_range) begin
								res_status_q <= STAT_RANGE;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_REGION;
							end
						end
						OP_REMOVE, OP_FIND: begin
							mode_q       <= M_MATCH;
							best_found_q <= 1'b0;
							idx_q        <= '0;
							state_q      <= S_SCAN;
						end
						default: begin
							res_status_q <= STAT_OK;
							state_q      <= S_RESP;
						end
					endcase
				end
				S_REGION: begin
					if (rgn_large && spare_exhausted) begin
						res_status_q <= STAT_NOSPARE;
						state_q      <= S_RESP;
					end else begin
						if (rgn_large) begin
							spare_used_q <= spare_used_q + SPW'(1);
						end
						mode_q   <= M_INSERT;
						placed_q <= 1'b0;
						idx_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						idx_q   <= '0;
						state_q <= S_SCAN_END;
					end else begin
						idx_q <= idx_q + SAW'(1);
					end
				end
				S_SCAN_END: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					unique case (mode_q)
						M_INSERT: begin
							valid_cnt_q  <= valid_cnt_q + VCW'(1);
							res_status_q <= STAT_OK;
							state_q      <= S_RESP;
						end
						M_MATCH: begin
							if (!best_found_q) begin
								res_status_q <= STAT_NOTFOUND;
								state_q      <= S_RESP;
							end else if (op_q == OP_FIND) begin
								res_status_q <= STAT_OK;
								res_found_q  <= best_exec_q;
								state_q      <= S_RESP;
							end else begin
								mode_q  <= M_REMOVE;
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						M_REMOVE: begin
							valid_cnt_q  <= valid_cnt_q - VCW'(1);
							res_status_q <= STAT_OK;
							state_q      <= S_RESP;
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {5'd0, res_found_q, res_status_q};
						state_q   <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
